/* hw/rtl/sos_pkg.sv */
// shared types, constants and helpers for the spiral order scanner
package sos_pkg;

   localparam int MAX_DIM = 8;
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int POS_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = 7;
   localparam int DATA_W  = 32;

   // register indexes on the csr port
   localparam logic REG_ROW_COUNT = 1'b0;
   localparam logic REG_COL_COUNT = 1'b1;

   // write beat into the matrix store
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } store_wr_type;

   // one spiral job handed from front to back
   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] cols;
      logic [CNT_W-1:0] total;
   } job_type;

   typedef enum logic [1:0] {
      DIR_RIGHT,
      DIR_DOWN,
      DIR_LEFT,
      DIR_UP
   } dir_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_WALK
   } back_state_type;

   // out of range sizes snap to 1 or MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [3:0] v);
      logic [DIM_W-1:0] r;
      if (v == 4'd0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

endpackage

/* hw/rtl/spiral_order_scanner_top.sv */
// Spiral order scanner top: loads a matrix row-major, replays it in clockwise spiral order.
// Load: one element beat per cycle while busy is low; rows*cols beats fill the matrix.
// Results: the beat that completes the matrix passes the job register, the job queue and the
// walker's idle state, then the registered store read gives rows*cols results, one per cycle,
// set by the single store read port; busy stays high until the last read, so loads wait for it.
// Reset: synchronous; clears control state, sets row/col count to 8; store is not cleared.
module spiral_order_scanner_top (
   input  logic                clock,
   input  logic                reset,
   // element beats
   input  logic                start,
   output logic                busy,
   input  logic signed [31:0]  req_element_value,
   // result beats
   output logic                rsp_strobe,
   output logic signed [31:0]  rsp_out_value,
   output logic                rsp_is_last,
   // csr port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import sos_pkg::*;

   logic [3:0]   row_count_ff, row_count_in;
   logic [3:0]   col_count_ff, col_count_in;
   logic         csr_wr;

   store_wr_type store_wr;
   logic         job_push, job_pop, job_empty, job_done;
   job_type      push_job, head_job;

   // csr write and read decode
   always_comb begin
      csr_wr       = psel && penable && pwrite;
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      prdata       = '0;
      case (paddr[2])
         REG_ROW_COUNT: begin
            prdata = {28'd0, row_count_ff};
            if (csr_wr) begin
               row_count_in = pwdata[3:0];
            end
         end
         REG_COL_COUNT: begin
            prdata = {28'd0, col_count_ff};
            if (csr_wr) begin
               col_count_in = pwdata[3:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= 4'd8;
         col_count_ff <= 4'd8;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   assign pready = 1'b1;

   sos_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_element_value (req_element_value),
      .row_count         (row_count_ff),
      .col_count         (col_count_ff),
      .job_done          (job_done),
      .busy              (busy),
      .store_wr          (store_wr),
      .job_push          (job_push),
      .job               (push_job)
   );

   sos_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .empty    (job_empty),
      .head_job (head_job)
   );

   sos_back u_back (
      .clock         (clock),
      .reset         (reset),
      .store_wr      (store_wr),
      .job_empty     (job_empty),
      .job           (head_job),
      .job_pop       (job_pop),
      .job_done      (job_done),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_value (rsp_out_value),
      .rsp_is_last   (rsp_is_last)
   );

endmodule

/* hw/rtl/sos_front.sv */
// front end: takes element beats, writes the store, issues spiral jobs
module sos_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [31:0]           req_element_value,
   input  logic [3:0]            row_count,
   input  logic [3:0]            col_count,
   input  logic                  job_done,
   output logic                  busy,
   output sos_pkg::store_wr_type store_wr,
   output logic                  job_push,
   output sos_pkg::job_type      job
);
   import sos_pkg::*;

   logic [CNT_W-1:0] load_cnt_ff, load_cnt_in;
   logic             pending_ff, pending_in;
   store_wr_type     wr_ff, wr_in;
   logic             push_ff, push_in;
   job_type          job_ff, job_in;

   logic [DIM_W-1:0] rows_eff, cols_eff;
   logic [CNT_W-1:0] total_eff;
   logic [CNT_W-1:0] cnt_next;
   logic             accept;

   // effective size and element total
   always_comb begin
      rows_eff  = clamp_dim(row_count);
      cols_eff  = clamp_dim(col_count);
      total_eff = CNT_W'(rows_eff) * CNT_W'(cols_eff);
      accept    = start && !pending_ff;
      cnt_next  = load_cnt_ff + CNT_W'(1);
   end

   // load counting and job issue
   always_comb begin
      load_cnt_in  = load_cnt_ff;
      pending_in   = pending_ff;
      wr_in.en     = 1'b0;
      wr_in.addr   = load_cnt_ff[ADDR_W-1:0];
      wr_in.data   = req_element_value;
      push_in      = 1'b0;
      job_in.rows  = rows_eff;
      job_in.cols  = cols_eff;
      job_in.total = total_eff;
      if (job_done) begin
         pending_in = 1'b0;
      end
      if (accept) begin
         wr_in.en = 1'b1;
         if (cnt_next >= total_eff) begin
            load_cnt_in = '0;
            push_in     = 1'b1;
            pending_in  = 1'b1;
         end else begin
            load_cnt_in = cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         pending_ff  <= 1'b0;
         wr_ff.en    <= 1'b0;
         push_ff     <= 1'b0;
      end else begin
         load_cnt_ff <= load_cnt_in;
         pending_ff  <= pending_in;
         wr_ff.en    <= wr_in.en;
         push_ff     <= push_in;
      end
      wr_ff.addr <= wr_in.addr;
      wr_ff.data <= wr_in.data;
      job_ff     <= job_in;
   end

   assign busy     = pending_ff;
   assign store_wr = wr_ff;
   assign job_push = push_ff;
   assign job      = job_ff;

`ifndef SYNTHESIS
   // the load count never runs past the store
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      32'(load_cnt_ff) < DEPTH)
      else $error("load count beyond store depth");

   // busy drops only when the back end reports the spiral finished
   a_busy_release: assert property (@(posedge clock) disable iff (reset)
      (pending_ff && !job_done) |=> pending_ff)
      else $error("busy released without job done");
`endif

endmodule

/* hw/rtl/sos_queue.sv */
// two entry job queue between front and back
module sos_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sos_pkg::job_type push_job,
   input  logic             pop,
   output logic             empty,
   output sos_pkg::job_type head_job
);
   import sos_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   // pointer and fill tracking
   always_comb begin
      do_pop    = pop && (count_ff != 2'd0);
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign empty    = (count_ff == 2'd0);
   assign head_job = entry_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   // a job is never pushed into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2))
      else $error("job queue overflow");
`endif

endmodule

/* hw/rtl/sos_back.sv */
// back end: matrix store and spiral walker driving the result beats
module sos_back (
   input  logic                  clock,
   input  logic                  reset,
   input  sos_pkg::store_wr_type store_wr,
   input  logic                  job_empty,
   input  sos_pkg::job_type      job,
   output logic                  job_pop,
   output logic                  job_done,
   output logic                  rsp_strobe,
   output logic signed [31:0]    rsp_out_value,
   output logic                  rsp_is_last
);
   import sos_pkg::*;

   logic [DATA_W-1:0] store_mem [DEPTH];

   back_state_type    state_ff, state_in;
   dir_type           dir_ff, dir_in;
   logic [POS_W-1:0]  r_ff, r_in, c_ff, c_in;
   logic [POS_W-1:0]  top_ff, top_in, bot_ff, bot_in;
   logic [POS_W-1:0]  lft_ff, lft_in, rgt_ff, rgt_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [DIM_W-1:0]  cols_ff, cols_in;

   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CNT_W-1:0]  idx;
   logic              last;

   logic              strobe_ff;
   logic              last_ff;
   logic [DATA_W-1:0] rd_data_ff;

   // walker state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dir_ff   <= dir_in;
      r_ff     <= r_in;
      c_ff     <= c_in;
      top_ff   <= top_in;
      bot_ff   <= bot_in;
      lft_ff   <= lft_in;
      rgt_ff   <= rgt_in;
      cnt_ff   <= cnt_in;
      total_ff <= total_in;
      cols_ff  <= cols_in;
   end

   // spiral walk: one store read per cycle, turn at each bound
   always_comb begin
      state_in = state_ff;
      dir_in   = dir_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      top_in   = top_ff;
      bot_in   = bot_ff;
      lft_in   = lft_ff;
      rgt_in   = rgt_ff;
      cnt_in   = cnt_ff;
      total_in = total_ff;
      cols_in  = cols_ff;
      job_pop  = 1'b0;
      rd_en    = 1'b0;
      idx      = CNT_W'(r_ff) * CNT_W'(cols_ff) + CNT_W'(c_ff);
      rd_addr  = idx[ADDR_W-1:0];
      last     = (cnt_ff == total_ff);
      job_done = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               state_in = BACK_WALK;
               dir_in   = DIR_RIGHT;
               r_in     = '0;
               c_in     = '0;
               top_in   = '0;
               lft_in   = '0;
               bot_in   = POS_W'(job.rows - DIM_W'(1));
               rgt_in   = POS_W'(job.cols - DIM_W'(1));
               cnt_in   = CNT_W'(1);
               total_in = job.total;
               cols_in  = job.cols;
            end
         end
         BACK_WALK: begin
            rd_en = 1'b1;
            if (last) begin
               job_done = 1'b1;
               state_in = BACK_IDLE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
               case (dir_ff)
                  DIR_RIGHT: begin
                     if (c_ff < rgt_ff) begin
                        c_in = c_ff + POS_W'(1);
                     end else begin
                        top_in = top_ff + POS_W'(1);
                        r_in   = r_ff + POS_W'(1);
                        dir_in = DIR_DOWN;
                     end
                  end
                  DIR_DOWN: begin
                     if (r_ff < bot_ff) begin
                        r_in = r_ff + POS_W'(1);
                     end else begin
                        rgt_in = rgt_ff - POS_W'(1);
                        c_in   = c_ff - POS_W'(1);
                        dir_in = DIR_LEFT;
                     end
                  end
                  DIR_LEFT: begin
                     if (c_ff > lft_ff) begin
                        c_in = c_ff - POS_W'(1);
                     end else begin
                        bot_in = bot_ff - POS_W'(1);
                        r_in   = r_ff - POS_W'(1);
                        dir_in = DIR_UP;
                     end
                  end
                  DIR_UP: begin
                     if (r_ff > top_ff) begin
                        r_in = r_ff - POS_W'(1);
                     end else begin
                        lft_in = lft_ff + POS_W'(1);
                        c_in   = c_ff + POS_W'(1);
                        dir_in = DIR_RIGHT;
                     end
                  end
                  default: begin
                     dir_in = DIR_RIGHT;
                  end
               endcase
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // matrix store, registered read feeds the result beat directly
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr] <= store_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // result beat strobe and last flag
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         strobe_ff <= rd_en;
         last_ff   <= rd_en && last;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_is_last   = last_ff;
   assign rsp_out_value = $signed(rd_data_ff);

`ifndef SYNTHESIS
   // the read that finishes a job shows up next cycle as the last beat
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      job_done |=> (strobe_ff && last_ff))
      else $error("job done not followed by last beat");

   // the walk count never passes the job total
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_WALK) |-> (cnt_ff <= total_ff))
      else $error("spiral walk ran past its total");
`endif

endmodule

/* test/tb.sv */
// testbench for the spiral order scanner: row-major loads checked against a spiral predictor
module tb;
   import sos_pkg::*;

   localparam int ITEM_TARGET  = 470;
   localparam int QUIET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } spiral_beat_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic signed [DATA_W-1:0] req_element_value;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_out_value;
   logic                     rsp_is_last;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [2:0]               paddr;
   logic [31:0]              pwdata;
   logic [31:0]              prdata;
   logic                     pready;

   // predictor state: shadow of the store, fill counter and size registers
   logic [DATA_W-1:0] matrix_shadow [DEPTH];
   logic [CNT_W-1:0]  fill_count;
   logic [3:0]        rows_cfg;
   logic [3:0]        cols_cfg;
   int unsigned       spiral_left;

   spiral_beat_type pending_beats[$];
   spiral_beat_type want;
   int              errors;
   int              elements_sent;
   int unsigned     cycles;
   bit              no_gaps;

   spiral_order_scanner_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_element_value (req_element_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_value     (rsp_out_value),
      .rsp_is_last       (rsp_is_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result checker: every strobed beat against the oldest predicted beat
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual value %0d last %0b",
                     $time, rsp_out_value, rsp_is_last);
            errors++;
         end else begin
            want = pending_beats.pop_front();
            if (rsp_out_value !== want.value) begin
               $display("%0t: out_value mismatch, expected %0d actual %0d",
                        $time, want.value, rsp_out_value);
               errors++;
            end
            if (rsp_is_last !== want.last) begin
               $display("%0t: is_last mismatch, expected %0b actual %0b",
                        $time, want.last, rsp_is_last);
               errors++;
            end
         end
      end
   end

   // zero snaps to one, anything above the max snaps to the max
   function automatic int unsigned dim_eff(logic [3:0] v);
      if (v == 4'd0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic void queue_cell(int unsigned idx);
      spiral_beat_type b;
      spiral_left--;
      b.value = matrix_shadow[ADDR_W'(idx)];
      b.last  = (spiral_left == 0);
      pending_beats.insert(pending_beats.size(), b);
   endfunction

   // clockwise rings: top, right, bottom if rows remain, left if cols remain
   function automatic void queue_spiral(int unsigned n_rows, int unsigned n_cols);
      int top, bot, lft, rgt, i;
      top = 0;
      bot = n_rows - 1;
      lft = 0;
      rgt = n_cols - 1;
      spiral_left = n_rows * n_cols;
      while (lft <= rgt && top <= bot) begin
         for (i = lft; i <= rgt; i++) queue_cell(top * n_cols + i);
         top++;
         for (i = top; i <= bot; i++) queue_cell(i * n_cols + rgt);
         rgt--;
         if (top <= bot) begin
            for (i = rgt; i >= lft; i--) queue_cell(bot * n_cols + i);
            bot--;
         end
         if (lft <= rgt) begin
            for (i = bot; i >= top; i--) queue_cell(i * n_cols + lft);
            lft++;
         end
      end
   endfunction

   // one accepted element: store it, emit the spiral once the matrix is full
   function automatic bit absorb_element(logic signed [DATA_W-1:0] v);
      int unsigned n_rows, n_cols;
      n_rows = dim_eff(rows_cfg);
      n_cols = dim_eff(cols_cfg);
      if (fill_count < DEPTH) matrix_shadow[fill_count[ADDR_W-1:0]] = v;
      fill_count = fill_count + 1'b1;
      if (fill_count >= n_rows * n_cols) begin
         fill_count = '0;
         queue_spiral(n_rows, n_cols);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_element();
      case ($urandom_range(0, 19))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return '0;
         3: return -32'sd1;
         default: return $urandom();
      endcase
   endfunction

   // one element beat; start stays high until the caller lowers it
   task automatic send_element(input logic signed [DATA_W-1:0] v, output bit emitted);
      start             <= 1'b1;
      req_element_value <= v;
      do @(posedge clock); while (busy !== 1'b0);
      emitted = absorb_element(v);
      elements_sent++;
   endtask

   // mostly short gaps, a few long ones
   task automatic idle_gap();
      int pick, gap;
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 50) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 3);
      else if (pick < 98) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // block drained and settled before touching a register
   task automatic wait_quiet();
      start <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic idx, input logic [3:0] val);
      wait_quiet();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {28'($urandom()), val};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (idx == REG_ROW_COUNT) rows_cfg = val;
      else cols_cfg = val;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_size(input logic [3:0] r, input logic [3:0] c);
      write_size(REG_ROW_COUNT, r);
      write_size(REG_COL_COUNT, c);
   endtask

   // full matrix at the current size
   task automatic send_matrix();
      bit emitted;
      emitted = 1'b0;
      while (!emitted) begin
         send_element(rand_element(), emitted);
         if (!emitted) idle_gap();
      end
   endtask

   // 1x1 spirals carrying the extreme values
   task automatic test_single_cells();
      bit emitted;
      set_size(4'd1, 4'd1);
      send_element(32'sh8000_0000, emitted);
      send_element(32'sh7fff_ffff, emitted);
      send_element('0, emitted);
      send_element(-32'sd1, emitted);
      send_element(32'sh5555_5555, emitted);
      send_element(32'shaaaa_aaaa, emitted);
   endtask

   // single row, single column and a 2x2 ring
   task automatic test_thin_shapes();
      set_size(4'd1, 4'd3);
      send_matrix();
      set_size(4'd3, 4'd1);
      send_matrix();
      set_size(4'd2, 4'd2);
      send_matrix();
   endtask

   // zero rows and oversize cols snap to a 1x8 row
   task automatic test_size_clamp();
      set_size(4'd0, 4'd15);
      send_matrix();
   endtask

   // shrink below the fill level mid-load: next element emits the smaller spiral
   task automatic test_resize_mid_load();
      bit emitted;
      set_size(4'd2, 4'd3);
      repeat (3) send_element(rand_element(), emitted);
      write_size(REG_COL_COUNT, 4'd1);
      send_element(rand_element(), emitted);
   endtask

   // reset-size matrix, the largest spiral
   task automatic test_full_size();
      set_size(4'd8, 4'd8);
      no_gaps = 1'b1;
      send_matrix();
      no_gaps = 1'b0;
   endtask

   // random sizes, mostly small, some resized while loading
   task automatic test_random_matrices();
      int pick, k, resize_at;
      logic [3:0] r, c;
      bit emitted;
      while (elements_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            r = 4'($urandom_range(1, 4));
            c = 4'($urandom_range(1, 4));
         end else if (pick < 9) begin
            r = 4'($urandom_range(0, 15));
            c = 4'($urandom_range(0, 15));
         end else begin
            r = 4'($urandom_range(5, 8));
            c = 4'($urandom_range(5, 8));
         end
         set_size(r, c);
         no_gaps   = ($urandom_range(0, 3) == 0);
         resize_at = ($urandom_range(0, 5) == 0) ?
                     $urandom_range(1, dim_eff(r) * dim_eff(c)) : -1;
         emitted = 1'b0;
         k = 0;
         while (!emitted) begin
            if (k == resize_at) write_size(logic'($urandom_range(0, 1)), 4'($urandom()));
            else if (k > 0) idle_gap();
            send_element(rand_element(), emitted);
            k++;
         end
      end
      no_gaps = 1'b0;
   endtask

   // main sequence
   initial begin
      reset             <= 1'b1;
      start             <= 1'b0;
      req_element_value <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      cycles            = 0;
      errors            = 0;
      elements_sent     = 0;
      no_gaps           = 1'b0;
      fill_count        = '0;
      rows_cfg          = 4'd8;
      cols_cfg          = 4'd8;
      spiral_left       = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_cells();
      test_thin_shapes();
      test_size_clamp();
      test_resize_mid_load();
      test_full_size();
      test_random_matrices();

      start <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/sos_pkg.sv
hw/rtl/sos_front.sv
hw/rtl/sos_queue.sv
hw/rtl/sos_back.sv
hw/rtl/spiral_order_scanner_top.sv
test/tb.sv
